// ----- sv/asda_pkg.sv -----
// ----------------------------------------------------------------------------
// asda_pkg
// Shared types, codes and constants of the angular sector distance averager.
// ----------------------------------------------------------------------------
package asda_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SECTORS_DEF = 360;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned AVG_W    = 16;
  localparam int unsigned SECTOR_W = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WIDTH_W  = 9;
  localparam int unsigned SUM_W    = 32;

  localparam int unsigned FULL_CIRCLE_DEG = 360;
  localparam int unsigned CDEG_PER_DEG    = 100;
  localparam int unsigned WIDTH_RESET     = 10;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_STORE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNSTORE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [ANGLE_W-1:0] angle_cdeg;
    logic [DIST_W-1:0]  distance_mm;
  } asda_req_t;

  typedef struct packed {
    logic [AVG_W-1:0]    avg_distance_mm;
    logic [SECTOR_W-1:0] sector_index;
    logic [STATUS_W-1:0] status;
  } asda_rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic req_load;   // latch request type and distance
    logic div_start;  // start the divider
    logic div_angle;  // divider operands: angle / sector width, else sum / count
    logic idx_clr;    // sweep index to zero
    logic idx_inc;    // sweep index + 1
    logic mem_rd;     // read all three sector stores
    logic addr_k;     // address = located sector, else sweep index
    logic clr;        // write zeros at sweep index
    logic upd;        // store / unstore write-back
    logic avg_we;     // write average at sweep index
    logic res_load;   // load result register
    logic res_upd;    // result carries sector, update status and query data
    logic res_range;  // result flags angle beyond last sector
  } asda_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic in_range;
    logic idx_last;
    logic cnt_zero;
  } asda_sts_t;

endpackage

// ----- sv/asda_div.sv -----
// ----------------------------------------------------------------------------
// asda_div
// Restoring divider, one quotient bit per cycle. A dividend shifted up by
// NumW - steps needs only that many steps.
// ----------------------------------------------------------------------------
module asda_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [$clog2(NumW+1)-1:0]     steps_i,
  input  logic [NumW-1:0]               num_i,
  input  logic [DenW-1:0]               den_i,
  output logic                          busy_o,
  output logic [NumW-1:0]               quo_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [StepW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]  quo_q;
  logic [DenW:0]    rem_q;
  logic [DenW-1:0]  den_q;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    den_ext;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    den_ext = {1'b0, den_q};
    ge      = rem_sh >= den_ext;
    cnt_d   = cnt_q;
    if (start_i) begin
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NumW-2:0], ge};
      rem_q <= ge ? (rem_sh - den_ext) : rem_sh;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

// ----- sv/asda_dp.sv -----
// ----------------------------------------------------------------------------
// asda_dp
// Datapath: width register, sector stores, divider, update arithmetic and
// result register.
// ----------------------------------------------------------------------------
module asda_dp #(
  parameter int unsigned MaxSectors = 360,
  parameter int unsigned CountBits  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [asda_pkg::WIDTH_W-1:0]         cfg_wdata_i,
  input  asda_pkg::asda_req_t                  req_i,
  input  asda_pkg::asda_cmd_t                  cmd_i,
  output asda_pkg::asda_sts_t                  sts_o,
  output asda_pkg::asda_rsp_t                  rsp_o
);

  import asda_pkg::*;

  localparam int unsigned AddrW = (MaxSectors > 1) ? $clog2(MaxSectors) : 1;
  localparam int unsigned DenW  = (CountBits > ANGLE_W) ? CountBits : ANGLE_W;
  localparam int unsigned StepW = $clog2(SUM_W + 1);
  localparam int unsigned ProdW = ANGLE_W + 1 + WIDTH_W;

  logic [WIDTH_W-1:0]  width_q;
  logic [REQ_W-1:0]    req_type_q;
  logic [DIST_W-1:0]   dist_q;
  logic [AddrW-1:0]    idx_q;

  logic [SUM_W-1:0]     sum_mem [MaxSectors];
  logic [CountBits-1:0] cnt_mem [MaxSectors];
  logic [AVG_W-1:0]     avg_mem [MaxSectors];
  logic [SUM_W-1:0]     sum_rd_q;
  logic [CountBits-1:0] cnt_rd_q;
  logic [AVG_W-1:0]     avg_rd_q;

  asda_rsp_t rsp_q, rsp_d;

  logic [SUM_W-1:0]   div_num;
  logic [DenW-1:0]    div_den;
  logic [StepW-1:0]   div_steps;
  logic               div_busy;
  logic [SUM_W-1:0]   quo;
  logic [ANGLE_W-1:0] span_cdeg;

  logic [ANGLE_W-1:0] k;
  logic [ANGLE_W:0]   k_inc;
  logic [ProdW-1:0]   prod;
  logic               in_range;
  logic [AddrW-1:0]   addr;

  logic               is_store, is_unstore, is_query;
  logic [SUM_W:0]     sum_add;
  logic               ovf, unf, cnt_zero, sc_we, sum_we, avg_we;
  logic [SUM_W-1:0]   sum_wd;
  logic [CountBits-1:0] cnt_wd;
  logic [AVG_W-1:0]   avg_wd;
  logic [STATUS_W-1:0] upd_status;

  // Registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(WIDTH_RESET);
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_type_q <= req_i.req_type;
      dist_q     <= req_i.distance_mm;
    end
    if (cmd_i.res_load) begin
      rsp_q <= rsp_d;
    end
  end

  // Divider: angle / (width * 100) in ANGLE_W steps, or sum / count in SUM_W
  assign span_cdeg = ANGLE_W'(width_q * 16'(CDEG_PER_DEG));

  always_comb begin
    if (cmd_i.div_angle) begin
      div_num   = {req_i.angle_cdeg, (SUM_W - ANGLE_W)'(0)};
      div_den   = DenW'(span_cdeg);
      div_steps = StepW'(ANGLE_W);
    end else begin
      div_num   = sum_rd_q;
      div_den   = DenW'(cnt_rd_q);
      div_steps = StepW'(SUM_W);
    end
  end

  asda_div #(
    .NumW (SUM_W),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .steps_i (div_steps),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Sector k is in use when k < MaxSectors and k < 360 / width, i.e. (k + 1) * width <= 360
  always_comb begin
    k        = quo[ANGLE_W-1:0];
    k_inc    = {1'b0, k} + (ANGLE_W + 1)'(1);
    prod     = ProdW'(k_inc) * ProdW'(width_q);
    in_range = (width_q != '0) && (k < ANGLE_W'(MaxSectors))
               && (prod <= ProdW'(FULL_CIRCLE_DEG));
    addr     = cmd_i.addr_k ? k[AddrW-1:0] : idx_q;
  end

  // Store / unstore arithmetic
  always_comb begin
    is_store   = req_type_q == REQ_STORE;
    is_unstore = req_type_q == REQ_UNSTORE;
    is_query   = req_type_q == REQ_QUERY;
    cnt_zero   = cnt_rd_q == '0;
    sum_add    = {1'b0, sum_rd_q} + (SUM_W + 1)'(dist_q);
    ovf        = sum_add[SUM_W] || (&cnt_rd_q);
    unf        = cnt_zero || (sum_rd_q < SUM_W'(dist_q));
    sc_we      = cmd_i.upd && ((is_store && !ovf) || (is_unstore && !unf));
    sum_we     = cmd_i.clr || sc_we;
    avg_we     = cmd_i.clr || cmd_i.avg_we;

    if (cmd_i.clr) begin
      sum_wd = '0;
      cnt_wd = '0;
    end else if (is_store) begin
      sum_wd = sum_add[SUM_W-1:0];
      cnt_wd = cnt_rd_q + CountBits'(1);
    end else begin
      sum_wd = sum_rd_q - SUM_W'(dist_q);
      cnt_wd = cnt_rd_q - CountBits'(1);
    end

    // saturate the quotient to 16 bits
    if (cmd_i.clr || cnt_zero) begin
      avg_wd = '0;
    end else if (|quo[SUM_W-1:AVG_W]) begin
      avg_wd = '1;
    end else begin
      avg_wd = quo[AVG_W-1:0];
    end

    if (is_store && ovf) begin
      upd_status = ST_OVERFLOW;
    end else if (is_unstore && unf) begin
      upd_status = ST_UNDERFLOW;
    end else begin
      upd_status = ST_OK;
    end

    rsp_d                 = '0;
    rsp_d.avg_distance_mm = (cmd_i.res_upd && is_query) ? avg_rd_q : '0;
    rsp_d.sector_index    = cmd_i.res_upd ? SECTOR_W'(k) : '0;
    if (cmd_i.res_range) begin
      rsp_d.status = ST_RANGE;
    end else if (cmd_i.res_upd) begin
      rsp_d.status = upd_status;
    end else begin
      rsp_d.status = ST_OK;
    end
  end

  // Sector stores
  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[addr] <= sum_wd;
    end
    if (cmd_i.mem_rd) begin
      sum_rd_q <= sum_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      cnt_mem[addr] <= cnt_wd;
    end
    if (cmd_i.mem_rd) begin
      cnt_rd_q <= cnt_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_we) begin
      avg_mem[addr] <= avg_wd;
    end
    if (cmd_i.mem_rd) begin
      avg_rd_q <= avg_mem[addr];
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.div_busy = div_busy;
    sts_o.in_range = in_range;
    sts_o.idx_last = idx_q == AddrW'(MaxSectors - 1);
    sts_o.cnt_zero = cnt_zero;
  end

  assign rsp_o = rsp_q;

endmodule

// ----- sv/asda_ctrl.sv -----
// ----------------------------------------------------------------------------
// asda_ctrl
// Controller: sequences locate / update, the average sweep and the clear
// sweep; owns busy and the result strobe.
// ----------------------------------------------------------------------------
module asda_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          cfg_we_i,
  input  logic [asda_pkg::REQ_W-1:0]    req_type_i,
  input  asda_pkg::asda_sts_t           sts_i,
  output asda_pkg::asda_cmd_t           cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);

  import asda_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_LOC   = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_CRD   = 7'b0010000,
    S_CDIV  = 7'b0100000,
    S_CWAIT = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  logic      clr_req_q, clr_req_d;
  logic      done_q, done_d;
  logic      avg_step;
  asda_cmd_t cmd;

  always_comb begin
    state_d   = state_q;
    clr_req_d = clr_req_q;
    done_d    = 1'b0;
    avg_step  = 1'b0;
    cmd       = '0;

    if (cfg_we_i) begin
      // new width: restart the clearing pass
      state_d     = S_CLR;
      clr_req_d   = 1'b0;
      cmd.idx_clr = 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd.req_load = 1'b1;
            unique case (req_type_i)
              REQ_STORE, REQ_UNSTORE, REQ_QUERY: begin
                cmd.div_start = 1'b1;
                cmd.div_angle = 1'b1;
                state_d       = S_LOC;
              end
              REQ_COMPUTE: begin
                cmd.idx_clr = 1'b1;
                state_d     = S_CRD;
              end
              REQ_CLEAR: begin
                cmd.idx_clr = 1'b1;
                clr_req_d   = 1'b1;
                state_d     = S_CLR;
              end
              default: begin
                // unknown request: all-zero result, nothing changes
                cmd.res_load = 1'b1;
                done_d       = 1'b1;
              end
            endcase
          end
        end
        S_CLR: begin
          cmd.clr = 1'b1;
          if (sts_i.idx_last) begin
            cmd.res_load = clr_req_q;
            done_d       = clr_req_q;
            clr_req_d    = 1'b0;
            state_d      = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
        S_LOC: begin
          if (!sts_i.div_busy) begin
            if (sts_i.in_range) begin
              cmd.mem_rd = 1'b1;
              cmd.addr_k = 1'b1;
              state_d    = S_UPD;
            end else begin
              cmd.res_load  = 1'b1;
              cmd.res_range = 1'b1;
              done_d        = 1'b1;
              state_d       = S_IDLE;
            end
          end
        end
        S_UPD: begin
          cmd.addr_k   = 1'b1;
          cmd.upd      = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_upd  = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end
        S_CRD: begin
          cmd.mem_rd = 1'b1;
          state_d    = S_CDIV;
        end
        S_CDIV: begin
          if (sts_i.cnt_zero) begin
            avg_step = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            state_d       = S_CWAIT;
          end
        end
        S_CWAIT: begin
          avg_step = !sts_i.div_busy;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase

      // write one average, then next sector or finish
      if (avg_step) begin
        cmd.avg_we = 1'b1;
        if (sts_i.idx_last) begin
          cmd.res_load = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_CRD;
        end
      end
    end
  end

  // Reset enters the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_req_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_req_q <= clr_req_d;
      done_q    <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  a_idx_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.idx_inc |-> !sts_i.idx_last)
    else $error("sweep index stepped past last sector");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mem_rd && cmd_o.addr_k) |-> sts_i.in_range)
    else $error("sector store addressed outside sectors in use");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");
`endif

endmodule

// ----- sv/angular_sector_distance_averager_unit.sv -----
// ----------------------------------------------------------------------------
// angular_sector_distance_averager_unit
// Per-sector range accumulator for a rotating rangefinder: store, unstore,
// compute averages, query and clear over sectors of a programmable width.
// ----------------------------------------------------------------------------
//
// Channel   Ports                        Handshake
// --------  ---------------------------  ---------------------------------
// request   start, busy, req_i           word taken when start & !busy & !cfg_we_i
// result    done_o, rsp_o                word valid for the done_o cycle
// config    cfg_we_i, cfg_wdata_i        sector width written when cfg_we_i
//
// Store, unstore and query run a 16-step angle divide, then read and update
// the located sector, or return a range status when the angle is past the
// last sector. Compute writes each sector's average, with a 32-step sum /
// count divide where the count is nonzero. Reset and every width write run
// a clearing pass over all sectors with busy high. The result strobe cannot
// be held off; busy is the only stall.
//
module angular_sector_distance_averager_unit #(
  parameter int unsigned MaxSectors = asda_pkg::MAX_SECTORS_DEF,
  parameter int unsigned CountBits  = asda_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request word
  input  logic                          start,
  output logic                          busy,
  input  asda_pkg::asda_req_t           req_i,
  // result word
  output logic                          done_o,
  output asda_pkg::asda_rsp_t           rsp_o,
  // sector width register
  input  logic                          cfg_we_i,
  input  logic [asda_pkg::WIDTH_W-1:0]  cfg_wdata_i
);

  import asda_pkg::*;

  asda_cmd_t cmd;
  asda_sts_t sts;

  // Sequencer: locate -> read -> update, or the per-sector sweeps
  asda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cfg_we_i   (cfg_we_i),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  // Sector stores, shared divider, update math, result register
  asda_dp #(
    .MaxSectors (MaxSectors),
    .CountBits  (CountBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
